// ===== hdl/ife_pkg.sv =====
package ife_pkg;

    // Length classes of the argument.
    localparam logic [2:0] LC_CHAR  = 3'd0;
    localparam logic [2:0] LC_SHORT = 3'd1;
    localparam logic [2:0] LC_INT   = 3'd2;
    localparam logic [2:0] LC_LONG  = 3'd3;
    localparam logic [2:0] LC_LLONG = 3'd4;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_OCT = 6'd8;
    localparam logic [5:0] RADIX_HEX = 6'd16;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;

    // A 64-bit magnitude has at most 64 digits (base two).
    localparam int DIGIT_DEPTH = 64;
    localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
    localparam int CHAR_W      = 8;
    // Run positions; wide enough for any field width and prefix.
    localparam int POS_W       = 8;

    localparam int MAX_CHARS_DEF = 64;

    typedef struct packed {
        logic load;   // latch a new item
        logic div;    // one byte step of the radix divider
        logic setup;  // digits complete, lay out the run
        logic pick;   // select the next character
        logic put;    // load the output register
    } t_cmd;

    typedef struct packed {
        logic chunk_last; // this divider step finishes a digit
        logic mag_zero;   // remaining quotient is zero
        logic out_free;   // output register can take a character next cycle
        logic last_put;   // the picked character ends the run
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [5:0] rem,
                                                     input logic upper);
        logic [CHAR_W-1:0] r8;
        r8 = {2'b00, rem};
        if (rem > 6'd9) begin
            digit_char = (upper ? CH_UPPER : CH_LOWER) + r8 - 8'd10;
        end else begin
            digit_char = CH_ZERO + r8;
        end
    endfunction

endpackage

// ===== hdl/ife_ram.sv =====
module ife_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ife_ctrl.sv =====
module ife_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ife_pkg::t_status i_status,
    output ife_pkg::t_cmd    o_cmd
);
    import ife_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.chunk_last) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.mag_zero) begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_PICK;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_PICK: begin
                if (i_status.out_free) begin
                    o_cmd.pick = 1'b1;
                    n_state    = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = i_status.last_put ? S_IDLE : S_PICK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/ife_dpath.sv =====
module ife_dpath #(
    parameter int MAX_CHARS = ife_pkg::MAX_CHARS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ife_pkg::t_cmd              i_cmd,
    output ife_pkg::t_status           o_status,
    input  logic [63:0]                i_raw_value,
    input  logic                       i_is_signed,
    input  logic [2:0]                 i_length_class,
    input  logic [5:0]                 i_radix,
    input  logic                       i_upper_case,
    input  logic                       i_left_align,
    input  logic                       i_zero_pad,
    input  logic                       i_show_sign,
    input  logic                       i_space_prefix,
    input  logic                       i_alternate_form,
    input  logic [6:0]                 i_field_width,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [ife_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_last_char
);
    import ife_pkg::*;

    // Item registers.
    logic [63:0]      r_mag;
    logic             r_neg;
    logic             r_vzero;
    logic [5:0]       r_base;
    logic             r_upper;
    logic             r_left;
    logic             r_zpad;
    logic             r_plus;
    logic             r_space;
    logic             r_alt;
    logic [6:0]       r_width;

    // Divider and digit count.
    logic [5:0]       r_rem;
    logic [2:0]       r_chunk;
    logic [DIGIT_AW:0] r_nd;

    // Run layout.
    logic [CHAR_W-1:0] r_pfx [3];
    logic [POS_W-1:0]  r_b1, r_b2, r_b3, r_b4, r_b5;
    logic [POS_W-1:0]  r_pos;

    // Picked character.
    logic [CHAR_W-1:0] r_pick_char;
    logic              r_pick_dig;
    logic              r_pick_last;

    // Output register.
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    // ---- Load: cut to the length class, sign, magnitude, radix clamp.
    logic [63:0] l_mask;
    logic [63:0] l_v;
    logic        l_msb;
    logic        l_neg;
    logic [63:0] l_mag;
    logic [5:0]  l_base;

    always_comb begin
        unique case (i_length_class) inside
            LC_CHAR:  l_mask = {56'b0, 8'hFF};
            LC_SHORT: l_mask = {48'b0, 16'hFFFF};
            LC_LONG, LC_LLONG: l_mask = '1;
            default:  l_mask = {32'b0, 32'hFFFF_FFFF};
        endcase
        l_v = i_raw_value & l_mask;
        unique case (i_length_class) inside
            LC_CHAR:  l_msb = l_v[7];
            LC_SHORT: l_msb = l_v[15];
            LC_LONG, LC_LLONG: l_msb = l_v[63];
            default:  l_msb = l_v[31];
        endcase
        l_neg = i_is_signed & l_msb;
        l_mag = l_neg ? ((~l_v + 64'd1) & l_mask) : l_v;
        if (i_radix < RADIX_MIN) begin
            l_base = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            l_base = RADIX_MAX;
        end else begin
            l_base = i_radix;
        end
    end

    // ---- Divider: eight restoring steps on the top byte of the magnitude.
    // The quotient byte is shifted in at the bottom, so after eight byte steps
    // r_mag holds the full quotient and d_rem the digit, which goes to the RAM.
    logic [6:0] d_rem7;
    logic [5:0] d_rem;
    logic [7:0] d_q;

    always_comb begin
        d_rem  = r_rem;
        d_q    = '0;
        d_rem7 = '0;
        for (int i = 7; i >= 0; i--) begin
            d_rem7 = {d_rem, r_mag[56+i]};
            if (d_rem7 >= {1'b0, r_base}) begin
                d_rem  = 6'(d_rem7 - {1'b0, r_base});
                d_q[i] = 1'b1;
            end else begin
                d_rem = d_rem7[5:0];
            end
        end
    end

    logic d_last;
    assign d_last = (r_chunk == 3'd7);

    // ---- Setup: prefix and segment boundaries of the run.
    logic              s_sign;
    logic [CHAR_W-1:0] s_sch;
    logic              s_alt16;
    logic              s_alt8;
    logic [1:0]        s_np;
    logic [POS_W-1:0]  s_total;
    logic [POS_W-1:0]  s_wid;
    logic [POS_W-1:0]  s_pad;
    logic [POS_W-1:0]  s_b1, s_b2, s_b3, s_b4, s_b5;

    always_comb begin
        s_sign  = r_neg | r_plus | r_space;
        s_sch   = r_neg ? CH_MINUS : (r_plus ? CH_PLUS : CH_SPACE);
        s_alt16 = r_alt && (r_base == RADIX_HEX);
        s_alt8  = r_alt && (r_base == RADIX_OCT) && !r_vzero;
        s_np    = {1'b0, s_sign} + (s_alt16 ? 2'd2 : {1'b0, s_alt8});
        s_total = POS_W'(r_nd) + POS_W'(s_np);
        s_wid   = POS_W'(r_width);
        s_pad   = (s_wid > s_total) ? (s_wid - s_total) : '0;
        s_b1    = (!r_left && !r_zpad) ? s_pad : '0;
        s_b2    = s_b1 + POS_W'(s_np);
        s_b3    = s_b2 + ((!r_left && r_zpad) ? s_pad : '0);
        s_b4    = s_b3 + POS_W'(r_nd);
        s_b5    = s_b4 + (r_left ? s_pad : '0);
    end

    // ---- Pick: character at the current run position.
    logic [POS_W-1:0]    p_off;
    logic [CHAR_W-1:0]   p_char;
    logic                p_dig;
    logic                p_last;
    logic [DIGIT_AW-1:0] p_raddr;
    logic [CHAR_W-1:0]   ram_rdata;

    always_comb begin
        p_off   = r_pos - r_b1;
        p_raddr = DIGIT_AW'(r_b4 - POS_W'(1) - r_pos);
        p_dig   = 1'b0;
        if (r_pos < r_b1) begin
            p_char = CH_SPACE;
        end else if (r_pos < r_b2) begin
            p_char = r_pfx[p_off[1:0]];
        end else if (r_pos < r_b3) begin
            p_char = CH_ZERO;
        end else if (r_pos < r_b4) begin
            p_char = CH_ZERO;
            p_dig  = 1'b1;
        end else begin
            p_char = CH_SPACE;
        end
        p_last = (r_pos == r_b5 - POS_W'(1)) || (r_pos == POS_W'(MAX_CHARS - 1));
    end

    ife_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (i_cmd.div && d_last),
        .i_waddr (r_nd[DIGIT_AW-1:0]),
        .i_wdata (digit_char(d_rem, r_upper)),
        .i_raddr (p_raddr),
        .o_rdata (ram_rdata)
    );

    // ---- Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag   <= l_mag;
            r_neg   <= l_neg;
            r_vzero <= (l_v == 64'd0);
            r_base  <= l_base;
            r_upper <= i_upper_case;
            r_left  <= i_left_align;
            r_zpad  <= i_zero_pad;
            r_plus  <= i_show_sign;
            r_space <= i_space_prefix;
            r_alt   <= i_alternate_form;
            r_width <= i_field_width;
        end else if (i_cmd.div) begin
            r_mag <= {r_mag[55:0], d_q};
        end
        if (i_cmd.setup) begin
            if (s_sign) begin
                r_pfx[0] <= s_sch;
                r_pfx[1] <= CH_ZERO;
                r_pfx[2] <= CH_X;
            end else begin
                r_pfx[0] <= CH_ZERO;
                r_pfx[1] <= CH_X;
                r_pfx[2] <= CH_X;
            end
            r_b1 <= s_b1;
            r_b2 <= s_b2;
            r_b3 <= s_b3;
            r_b4 <= s_b4;
            r_b5 <= s_b5;
        end
        if (i_cmd.pick) begin
            r_pick_char <= p_char;
            r_pick_dig  <= p_dig;
            r_pick_last <= p_last;
        end
        if (i_cmd.put) begin
            r_out_char <= r_pick_dig ? ram_rdata : r_pick_char;
            r_out_last <= r_pick_last;
        end
    end

    // ---- Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_chunk     <= '0;
            r_nd        <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rem   <= '0;
                r_chunk <= '0;
                r_nd    <= '0;
                r_pos   <= '0;
            end else if (i_cmd.div) begin
                r_rem   <= d_last ? 6'd0 : d_rem;
                r_chunk <= r_chunk + 3'd1;
                if (d_last) begin
                    r_nd <= r_nd + 1'b1;
                end
            end else if (i_cmd.pick) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.chunk_last = d_last;
    assign o_status.mag_zero   = (r_mag == 64'd0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.last_put   = r_pick_last;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

// ===== hdl/integer_format_emitter_core.sv =====
// Formats one integer argument the way printf formats %d, %u, %o, %x and
// their relatives, and streams the result out one ASCII character per item,
// with o_last_char set on the final character of the run. The value is cut
// to its length class, sign-extended when signed, and shown as '-' and its
// magnitude when negative; digits above nine use letters, capital when
// i_upper_case is set. A sign, plus or space prefix and the alternate-form
// "0x" or "0" prefix come ahead of the digits, and the run is padded with
// spaces or zeros up to i_field_width. Runs longer than MAX_CHARS are cut.
// Sequence: after an item is accepted, each digit takes eight byte steps
// of the shared radix divider, which works through the 64-bit magnitude
// one byte per cycle, plus one check; each emitted character is picked,
// waiting while the output register is full, and then loaded into it,
// because digits are read back from the digit RAM, whose read is
// registered. A new item is accepted as soon as the last character sits
// in the output register.

module integer_format_emitter_core #(
    parameter int MAX_CHARS = ife_pkg::MAX_CHARS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // Input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [63:0]                i_raw_value,
    input  logic                       i_is_signed,
    input  logic [2:0]                 i_length_class,
    input  logic [5:0]                 i_radix,
    input  logic                       i_upper_case,
    input  logic                       i_left_align,
    input  logic                       i_zero_pad,
    input  logic                       i_show_sign,
    input  logic                       i_space_prefix,
    input  logic                       i_alternate_form,
    input  logic [6:0]                 i_field_width,

    // Output channel.
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ife_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_last_char
);
    import ife_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // The controller sequences load, digit extraction and emission.
    ife_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the item, the divider, the digit RAM, the run
    // layout and the output register.
    ife_dpath #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_raw_value      (i_raw_value),
        .i_is_signed      (i_is_signed),
        .i_length_class   (i_length_class),
        .i_radix          (i_radix),
        .i_upper_case     (i_upper_case),
        .i_left_align     (i_left_align),
        .i_zero_pad       (i_zero_pad),
        .i_show_sign      (i_show_sign),
        .i_space_prefix   (i_space_prefix),
        .i_alternate_form (i_alternate_form),
        .i_field_width    (i_field_width),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_out_char       (o_out_char),
        .o_last_char      (o_last_char)
    );

    // Once an item is taken, the block is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // A character is only loaded into an empty output register.
    a_put_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.put |-> !o_out_valid)
        else $error("output register overwritten");

    // Every pick is followed by its load into the output register.
    a_pick_then_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pick |=> (w_cmd.put && o_in_ready == 1'b0))
        else $error("picked character not loaded");

    // Digit extraction never runs while an item is loaded or characters are picked or put.
    a_div_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.div && (w_cmd.pick || w_cmd.put || w_cmd.load)))
        else $error("divider active outside digit phase");

endmodule
